>>> sv/lrupr_pkg.sv
package lrupr_pkg;

  localparam int MAX_FRAMES = 8;
  localparam int PAGE_BITS  = 16;
  localparam int FIDX_W     = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CNT_W      = $clog2(MAX_FRAMES + 1);
  localparam int RANK_W     = FIDX_W;
  localparam int CFG_W      = 4;
  localparam int FAULT_W    = 32;
  localparam int RESET_FRAMES = (MAX_FRAMES < 8) ? MAX_FRAMES : 8;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DRAIN  = 4'b0100,
    S_DECIDE = 4'b1000
  } state_t;

  // Running result of one scan over the filled frames.
  typedef struct packed {
    logic                 hit;
    logic [FIDX_W-1:0]    hit_idx;
    logic [RANK_W-1:0]    best_rank;
    logic [FIDX_W-1:0]    best_idx;
    logic [PAGE_BITS-1:0] best_page;
  } scan_res_t;

endpackage

>>> sv/lrupr_page_store.sv
module lrupr_page_store (
  input  logic                           clk,
  input  logic                           we,
  input  logic [lrupr_pkg::FIDX_W-1:0]    waddr,
  input  logic [lrupr_pkg::PAGE_BITS-1:0] wdata,
  input  logic [lrupr_pkg::FIDX_W-1:0]    raddr,
  output logic [lrupr_pkg::PAGE_BITS-1:0] rdata
);
  import lrupr_pkg::*;

  logic [PAGE_BITS-1:0] mem [MAX_FRAMES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/lrupr_match_unit.sv
module lrupr_match_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           clr,
  input  logic                           vld,
  input  logic [lrupr_pkg::FIDX_W-1:0]    idx,
  input  logic [lrupr_pkg::PAGE_BITS-1:0] key,
  input  logic [lrupr_pkg::PAGE_BITS-1:0] rd_page,
  input  logic [lrupr_pkg::RANK_W-1:0]    rd_rank,
  output lrupr_pkg::scan_res_t            res
);
  import lrupr_pkg::*;

  // One frame per cycle: compare against the key and track the oldest rank.
  always_ff @(posedge clk) begin
    if (rst || clr) begin
      res.hit <= 1'b0;
    end else if (vld && !res.hit && rd_page == key) begin
      res.hit <= 1'b1;
    end
    if (vld && !res.hit && rd_page == key) begin
      res.hit_idx <= idx;
    end
    if (vld && (idx == '0 || rd_rank > res.best_rank)) begin
      res.best_rank <= rd_rank;
      res.best_idx  <= idx;
      res.best_page <= rd_page;
    end
  end

endmodule

>>> sv/lru_page_replacement.sv
// LRU page replacement: one page reference in, one hit/fault result out.
// From input transfer to output valid, the match unit reads each filled frame (none
// when no frame is filled) through the page memory read port, one frame per cycle; the
// number of occupied frames is 0..8. The decision then waits for a free output register.
// No new reference is taken until the result is committed; in_ready is low meanwhile.
// Reset (synchronous, active high): all frames empty, fault counter zero, frames_in_use 8.
module lru_page_replacement (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [lrupr_pkg::CFG_W-1:0]     cfg_wr_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [15:0]                     page_number,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            hit,
  output logic [2:0]                      frame_index,
  output logic                            evicted_valid,
  output logic [15:0]                     evicted_page,
  output logic [lrupr_pkg::FAULT_W-1:0]   fault_total
);
  import lrupr_pkg::*;

  state_t               state, state_next;
  logic [CNT_W-1:0]     frames_in_use;
  logic [CNT_W-1:0]     frames_filled;
  logic [RANK_W-1:0]    recency [MAX_FRAMES];
  logic [FAULT_W-1:0]   fault_counter;
  logic [PAGE_BITS-1:0] key;

  // Scan pointer and the tag of the data coming back from the page memory.
  logic [FIDX_W-1:0]    scan_idx;
  logic                 rd_vld;
  logic [FIDX_W-1:0]    rd_idx;
  logic [PAGE_BITS-1:0] rd_page;
  scan_res_t            res;

  logic                 in_xfer;
  logic                 last_issue;
  logic                 commit;
  logic                 miss, fill, age_all;
  logic [FIDX_W-1:0]    f;
  logic [RANK_W-1:0]    limit;
  logic [CNT_W-1:0]     filled_new;
  logic [FAULT_W-1:0]   fault_next;
  logic [CNT_W-1:0]     cfg_clamped;

  assign in_ready   = (state == S_IDLE);
  assign in_xfer    = in_valid && in_ready;
  assign last_issue = ({1'b0, scan_idx} == CNT_W'(frames_filled - 1'b1));
  // Hold the decision until the output register is free.
  assign commit     = (state == S_DECIDE) && (!out_valid || out_ready);

  always_comb begin
    if (cfg_wr_data == '0) begin
      cfg_clamped = CNT_W'(1);
    end else if (32'(cfg_wr_data) > MAX_FRAMES) begin
      cfg_clamped = CNT_W'(MAX_FRAMES);
    end else begin
      cfg_clamped = CNT_W'(cfg_wr_data);
    end
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_xfer) begin
          state_next = (frames_filled == '0) ? S_DECIDE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (last_issue) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN:  state_next = S_DECIDE;
      S_DECIDE: begin
        if (commit) begin
          state_next = S_IDLE;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      rd_vld <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= (state == S_SCAN);
    end
    rd_idx <= scan_idx;
    if (in_xfer) begin
      key      <= page_number[PAGE_BITS-1:0];
      scan_idx <= '0;
    end else if (state == S_SCAN && !last_issue) begin
      scan_idx <= scan_idx + 1'b1;
    end
  end

  // Decision: hit frame, next empty frame, or the least recently used one.
  always_comb begin
    miss       = !res.hit;
    fill       = miss && (frames_filled < frames_in_use);
    age_all    = fill;
    filled_new = fill ? frames_filled + 1'b1 : frames_filled;
    if (res.hit) begin
      f = res.hit_idx;
    end else if (fill) begin
      f = FIDX_W'(frames_filled);
    end else begin
      f = res.best_idx;
    end
    limit = res.hit ? recency[res.hit_idx] : res.best_rank;
    if (miss && fault_counter != '1) begin
      fault_next = fault_counter + 1'b1;
    end else begin
      fault_next = fault_counter;
    end
  end

  lrupr_page_store u_store (
    .clk   (clk),
    .we    (commit && miss),
    .waddr (f),
    .wdata (key),
    .raddr (scan_idx),
    .rdata (rd_page)
  );

  lrupr_match_unit u_match (
    .clk     (clk),
    .rst     (rst),
    .clr     (in_xfer),
    .vld     (rd_vld),
    .idx     (rd_idx),
    .key     (key),
    .rd_page (rd_page),
    .rd_rank (recency[rd_idx]),
    .res     (res)
  );

  // Frame bookkeeping; a register write empties every frame.
  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= CNT_W'(RESET_FRAMES);
      frames_filled <= '0;
      fault_counter <= '0;
      for (int j = 0; j < MAX_FRAMES; j++) begin
        recency[j] <= '0;
      end
    end else if (cfg_wr_en) begin
      frames_in_use <= cfg_clamped;
      frames_filled <= '0;
      for (int j = 0; j < MAX_FRAMES; j++) begin
        recency[j] <= '0;
      end
    end else if (commit) begin
      frames_filled <= filled_new;
      fault_counter <= fault_next;
      // Touch: the chosen frame becomes newest, younger filled frames age (all of them on a fill).
      for (int j = 0; j < MAX_FRAMES; j++) begin
        if (FIDX_W'(j) == f) begin
          recency[j] <= '0;
        end else if (CNT_W'(j) < filled_new && (age_all || recency[j] < limit)) begin
          recency[j] <= recency[j] + 1'b1;
        end
      end
    end
  end

  // Output register: load on commit, drop on transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (commit) begin
      hit           <= res.hit;
      frame_index   <= 3'(f);
      evicted_valid <= miss && !fill;
      evicted_page  <= (miss && !fill) ? 16'(res.best_page) : '0;
      fault_total   <= fault_next;
    end
  end

endmodule
